FILE: hdl/bmp_pkg.sv
`timescale 1ns / 1ps
// bmp_pkg: shared types, codes and constants of the banked memory pager
// no dependencies

package bmp_pkg;

  localparam int unsigned CmdW     = 2;
  localparam int unsigned AddrW    = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned TargetW  = 2;
  localparam int unsigned PhysW    = 20;
  localparam int unsigned OffsetW  = 14;
  localparam int unsigned BankW    = PhysW - OffsetW;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 1;

  typedef enum logic [CmdW-1:0] {
    CMD_MEM_RD   = 2'd0,
    CMD_MEM_WR   = 2'd1,
    CMD_PORT_OUT = 2'd2,
    CMD_RESET    = 2'd3
  } cmd_e;

  typedef enum logic [TargetW-1:0] {
    TGT_NONE = 2'd0,
    TGT_ROM  = 2'd1,
    TGT_RAM  = 2'd2
  } target_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLE_512K  = 1'b0,
    CFG_ENABLE_1024K = 1'b1
  } cfg_idx_e;

  // fixed banks of the middle windows
  localparam logic [BankW-1:0] BANK_WIN1 = 6'd5;
  localparam logic [BankW-1:0] BANK_WIN2 = 6'd2;

  // paging port decode
  localparam logic [AddrW-1:0] PORT_MASK  = 16'h8003;
  localparam logic [AddrW-1:0] PORT_MATCH = 16'h0001;
  localparam logic [AddrW-1:0] PORT_FULL  = 16'h7FFD;

  localparam int unsigned LOCK_BIT     = 5;
  localparam int unsigned ROM_HALF_BIT = 4;

  typedef struct packed {
    logic enable_512k;
    logic enable_1024k;
  } cfg_t;

  typedef struct packed {
    cmd_e             cmd;
    logic [AddrW-1:0] address;
    logic [ByteW-1:0] data_in;
    logic             ram_over_rom;
    logic             high_lock;
  } in_item_t;

  typedef struct packed {
    target_e          target;
    logic [PhysW-1:0] phys_address;
    logic             write_strobe;
    logic [ByteW-1:0] write_byte;
    logic [ByteW-1:0] paging_value;
  } out_item_t;

endpackage

FILE: hdl/bmp_if.sv
`timescale 1ns / 1ps
// bmp_in_if / bmp_out_if: valid-ready channels of the banked memory pager
// depends on bmp_pkg for field widths

interface bmp_in_if import bmp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  cmd;
  logic [AddrW-1:0] address;
  logic [ByteW-1:0] data_in;
  logic             ram_over_rom;
  logic             high_lock;

  modport source (output valid, cmd, address, data_in, ram_over_rom, high_lock,
                  input ready);
  modport sink (input valid, cmd, address, data_in, ram_over_rom, high_lock,
                output ready);
endinterface

interface bmp_out_if import bmp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TargetW-1:0] target;
  logic [PhysW-1:0]   phys_address;
  logic               write_strobe;
  logic [ByteW-1:0]   write_byte;
  logic [ByteW-1:0]   paging_value;

  modport source (output valid, target, phys_address, write_strobe, write_byte,
                  paging_value, input ready);
  modport sink (input valid, target, phys_address, write_strobe, write_byte,
                paging_value, output ready);
endinterface

FILE: hdl/bmp_port.sv
`timescale 1ns / 1ps
// bmp_port: next value of the paging latch for one item
// depends on bmp_pkg

module bmp_port import bmp_pkg::*; (
  input  cfg_t             cfg_i,
  input  in_item_t         item_i,
  input  logic [ByteW-1:0] latch_i,
  output logic [ByteW-1:0] latch_o
);

  logic             match;
  logic             himem;
  logic             ext1024;
  logic             blocked;
  logic             full_store;
  logic [ByteW-1:0] store_val;

  assign match      = (item_i.address & PORT_MASK) == PORT_MATCH;
  assign himem      = ~item_i.high_lock;
  assign ext1024    = cfg_i.enable_512k & cfg_i.enable_1024k;
  assign blocked    = latch_i[LOCK_BIT] & ~(ext1024 & himem);
  assign full_store = cfg_i.enable_512k & (item_i.address == PORT_FULL) & himem;
  assign store_val  = full_store ? item_i.data_in : {2'b00, item_i.data_in[5:0]};

  always_comb begin
    latch_o = latch_i;
    unique case (item_i.cmd)
      CMD_RESET: latch_o = '0;
      CMD_PORT_OUT: begin
        if (match && !blocked) latch_o = store_val;
      end
      default: latch_o = latch_i;
    endcase
  end

endmodule

FILE: hdl/bmp_xlate.sv
`timescale 1ns / 1ps
// bmp_xlate: cpu address to physical rom / ram address translation
// depends on bmp_pkg

module bmp_xlate import bmp_pkg::*; (
  input  cfg_t             cfg_i,
  input  in_item_t         item_i,
  input  logic [ByteW-1:0] latch_i,
  output target_e          target_o,
  output logic [PhysW-1:0] phys_o,
  output logic             strobe_o,
  output logic [ByteW-1:0] wbyte_o
);

  logic [OffsetW-1:0] offset;
  logic [BankW-1:0]   top_bank;
  logic [BankW-1:0]   bank;
  logic               is_rom;
  logic               is_mem;

  assign offset = item_i.address[OffsetW-1:0];
  assign is_mem = (item_i.cmd == CMD_MEM_RD) || (item_i.cmd == CMD_MEM_WR);

  always_comb begin
    if (cfg_i.enable_512k && cfg_i.enable_1024k) begin
      top_bank = {latch_i[7:5], latch_i[2:0]};
    end else if (cfg_i.enable_512k) begin
      top_bank = {1'b0, latch_i[7:6], latch_i[2:0]};
    end else begin
      top_bank = {3'b000, latch_i[2:0]};
    end
  end

  always_comb begin
    is_rom = 1'b0;
    unique case (item_i.address[AddrW-1:OffsetW])
      2'd0: begin
        is_rom = ~item_i.ram_over_rom;
        bank   = item_i.ram_over_rom ? '0 : {5'd0, latch_i[ROM_HALF_BIT]};
      end
      2'd1: bank = BANK_WIN1;
      2'd2: bank = BANK_WIN2;
      default: bank = top_bank;
    endcase
  end

  always_comb begin
    target_o = TGT_NONE;
    phys_o   = '0;
    strobe_o = 1'b0;
    wbyte_o  = '0;
    if (is_mem) begin
      target_o = is_rom ? TGT_ROM : TGT_RAM;
      phys_o   = {bank, offset};
      if (item_i.cmd == CMD_MEM_WR && !is_rom) begin
        strobe_o = 1'b1;
        wbyte_o  = item_i.data_in;
      end
    end
  end

endmodule

FILE: hdl/banked_memory_pager.sv
`timescale 1ns / 1ps
// banked_memory_pager: top level of the paging unit
// depends on bmp_pkg, bmp_if.sv, bmp_port, bmp_xlate

// The pager takes one transfer per clock on in_if while out_if does not stall
// it and returns exactly one result per transfer on out_if, in order. A
// transfer is held in an input register, translated by a short combinational
// path (window decode, bank select, paging latch update) and loaded into the
// result register, so the sustained rate is one item per cycle while out_if is
// ready; the paging latch is updated on the same edge that loads the result,
// so the next item always sees the latch left by the one before it. A stalled result
// holds the pipe without losing items. The two mode registers are written
// through cfg_we_i / cfg_index_i / cfg_data_i and should only change while
// the pager is idle.

module banked_memory_pager import bmp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  bmp_in_if.sink              in_if,
  bmp_out_if.source           out_if
);

  // mode registers
  cfg_t cfg_q;

  // input register
  logic     s1_valid_q;
  in_item_t s1_q;

  // result register
  logic      out_valid_q;
  out_item_t out_q;
  out_item_t out_d;

  // paging latch
  logic [ByteW-1:0] latch_q;
  logic [ByteW-1:0] latch_d;

  logic advance;   // input register moves into result register
  logic in_fire;
  cfg_idx_e cfg_idx;

  assign advance     = s1_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !s1_valid_q || advance;
  assign in_fire     = in_if.valid && in_if.ready;
  assign cfg_idx     = cfg_idx_e'(cfg_index_i);

  // mode register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx)
        CFG_ENABLE_512K:  cfg_q.enable_512k  <= cfg_data_i[0];
        CFG_ENABLE_1024K: cfg_q.enable_1024k <= cfg_data_i[0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  // input stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_q <= in_if.valid;
    end
  end

  // input stage payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.cmd          <= cmd_e'(in_if.cmd);
      s1_q.address      <= in_if.address;
      s1_q.data_in      <= in_if.data_in;
      s1_q.ram_over_rom <= in_if.ram_over_rom;
      s1_q.high_lock    <= in_if.high_lock;
    end
  end

  // latch update for the item in the input register
  bmp_port u_port (
    .cfg_i   (cfg_q),
    .item_i  (s1_q),
    .latch_i (latch_q),
    .latch_o (latch_d)
  );

  // address translation against the latch seen by this item
  bmp_xlate u_xlate (
    .cfg_i    (cfg_q),
    .item_i   (s1_q),
    .latch_i  (latch_q),
    .target_o (out_d.target),
    .phys_o   (out_d.phys_address),
    .strobe_o (out_d.write_strobe),
    .wbyte_o  (out_d.write_byte)
  );

  // result reports the latch after this item
  assign out_d.paging_value = latch_d;

  // latch and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        latch_q <= latch_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.target       = out_q.target;
  assign out_if.phys_address = out_q.phys_address;
  assign out_if.write_strobe = out_q.write_strobe;
  assign out_if.write_byte   = out_q.write_byte;
  assign out_if.paging_value = out_q.paging_value;

  // a reset command clears the latch
  a_reset_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_q.cmd == CMD_RESET) |=> (latch_q == '0))
    else $error("paging latch not cleared by reset command");

  // the held result always reports the live latch
  a_value_tracks_latch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.paging_value == latch_q))
    else $error("paging value out of step with latch");

  // rom is never written
  a_rom_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.target == TGT_ROM) |-> !out_q.write_strobe)
    else $error("write strobe on rom access");

  // the latch moves only when an item reaches the result register
  a_latch_moves_on_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(latch_q))
    else $error("paging latch changed without an item");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for banked_memory_pager, with its own paging
// model, random bursty traffic, receiver stalls and a long result hold-off
// depends on bmp_pkg, bmp_if.sv and banked_memory_pager

module testbench;
  import bmp_pkg::*;

  localparam int unsigned HalfPeriod    = 4;
  localparam int unsigned DrainCycles   = 6;   // pipe is two deep, leave some slack
  localparam int unsigned HoldOffCycles = 100;
  localparam int unsigned ItemsPerMode  = 270;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  bmp_in_if  in_if ();
  bmp_out_if out_if ();

  banked_memory_pager dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_if       (in_if),
    .out_if      (out_if)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #(HalfPeriod);
    clk_i = 1'b1;
    #(HalfPeriod);
  end

  // ---------------------------------------------------------------------------
  // paging model: mirror of the latch and of the two mode bits
  // ---------------------------------------------------------------------------
  logic [ByteW-1:0] latch_model;
  logic             mode_512k;
  logic             mode_1024k;

  // translations still owed by the pager, oldest first
  out_item_t pending_translations[$];

  int unsigned error_count;
  int unsigned results_seen;
  int unsigned cmd_count[4];

  // sender pacing and receiver hold-off request
  int          burst_left;
  bit          gaps_on;
  bit          hold_off_req;

  // works out the result of one access and moves the latch model on
  function automatic out_item_t translate_access(in_item_t acc);
    out_item_t          res;
    logic [BankW-1:0]   bank;
    logic [OffsetW-1:0] offset;
    logic               himem;
    logic               ext_1024k;
    res        = '0;
    res.target = TGT_NONE;
    bank       = '0;
    offset     = acc.address[OffsetW-1:0];
    himem      = !acc.high_lock;
    ext_1024k  = mode_512k && mode_1024k;
    case (acc.cmd)
      CMD_MEM_RD, CMD_MEM_WR: begin
        case (acc.address[AddrW-1:OffsetW])
          2'd0: bank = '0;
          2'd1: bank = BANK_WIN1;
          2'd2: bank = BANK_WIN2;
          default: begin
            // top window: bank grows with the mode bits
            if (ext_1024k) begin
              bank = {latch_model[7:5], latch_model[2:0]};
            end else if (mode_512k) begin
              bank = {1'b0, latch_model[7:6], latch_model[2:0]};
            end else begin
              bank = {3'b000, latch_model[2:0]};
            end
          end
        endcase
        if (acc.address[AddrW-1:OffsetW] == 2'd0 && !acc.ram_over_rom) begin
          // rom: latch bit picks the half, writes are dropped
          res.target       = TGT_ROM;
          res.phys_address = {5'd0, latch_model[ROM_HALF_BIT], offset};
        end else begin
          res.target       = TGT_RAM;
          res.phys_address = {bank, offset};
          if (acc.cmd == CMD_MEM_WR) begin
            res.write_strobe = 1'b1;
            res.write_byte   = acc.data_in;
          end
        end
      end
      CMD_PORT_OUT: begin
        if ((acc.address & PORT_MASK) == PORT_MATCH &&
            !(latch_model[LOCK_BIT] && !(ext_1024k && himem))) begin
          if (mode_512k && acc.address == PORT_FULL && himem) begin
            latch_model = acc.data_in;
          end else begin
            latch_model = {2'b00, acc.data_in[5:0]};
          end
        end
      end
      default: begin
        latch_model = '0;
      end
    endcase
    res.paging_value = latch_model;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: one transfer per call, bursts with, while gaps_on is set, random gaps between them
  // ---------------------------------------------------------------------------
  task automatic send_access(cmd_e cmd, logic [AddrW-1:0] addr, logic [ByteW-1:0] data,
                             bit ram_over_rom, bit high_lock);
    in_item_t acc;
    int       gap;
    acc = '{cmd: cmd, address: addr, data_in: data, ram_over_rom: ram_over_rom,
            high_lock: high_lock};
    @(negedge clk_i);
    in_if.valid        = 1'b1;
    in_if.cmd          = acc.cmd;
    in_if.address      = acc.address;
    in_if.data_in      = acc.data_in;
    in_if.ram_over_rom = acc.ram_over_rom;
    in_if.high_lock    = acc.high_lock;
    do @(posedge clk_i); while (!in_if.ready);
    // transfer taken on this edge: predict now, in order of acceptance
    pending_translations.push_back(translate_access(acc));
    cmd_count[acc.cmd]++;
    burst_left--;
    if (burst_left <= 0) begin
      // mostly short bursts, now and then a long unbroken run
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 30) : $urandom_range(12, 1);
      if (gaps_on) begin
        gap = $urandom_range(6, 1);
        repeat (gap) begin
          @(negedge clk_i);
          // valid low, payload left as noise
          in_if.valid        = 1'b0;
          in_if.cmd          = CmdW'($urandom_range(3));
          in_if.address      = AddrW'($urandom_range(16'hFFFF));
          in_if.data_in      = ByteW'($urandom_range(8'hFF));
          in_if.ram_over_rom = 1'($urandom_range(1));
          in_if.high_lock    = 1'($urandom_range(1));
        end
      end
    end
  endtask

  // random access, biased towards ports that the latch decodes
  task automatic send_random();
    cmd_e             cmd;
    logic [AddrW-1:0] addr;
    int unsigned      pick;
    pick = $urandom_range(99);
    if (pick < 35) begin
      cmd = CMD_MEM_RD;
    end else if (pick < 70) begin
      cmd = CMD_MEM_WR;
    end else if (pick < 92) begin
      cmd = CMD_PORT_OUT;
    end else begin
      cmd = CMD_RESET;
    end
    addr = AddrW'($urandom_range(16'hFFFF));
    if (cmd == CMD_PORT_OUT) begin
      case ($urandom_range(3))
        0:       addr = PORT_FULL;
        1, 2:    addr = (addr & ~PORT_MASK) | PORT_MATCH;
        default: ;  // any port, mostly not decoded
      endcase
    end
    send_access(cmd, addr, ByteW'($urandom_range(8'hFF)), $urandom_range(99) < 30,
                1'($urandom_range(1)));
  endtask

  // drop valid and let every owed result come back
  task automatic wait_idle();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (pending_translations.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // mode register write, only with the pager idle
  task automatic set_mode(cfg_idx_e idx, bit value);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_ENABLE_512K) begin
      mode_512k = value;
    end else begin
      mode_1024k = value;
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: stall rate changes from phase to phase, plus an on-demand hold-off
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall_pct;
    int phase_left;
    stall_pct    = 0;
    phase_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        // long stall so that the pipe fills and the input backs up
        out_if.ready = 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      if (phase_left <= 0) begin
        phase_left = $urandom_range(80, 20);
        case ($urandom_range(4))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 20;
          3:       stall_pct = 50;
          default: stall_pct = 80;
        endcase
      end
      phase_left--;
      out_if.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // each result transfer against the oldest prediction
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (pending_translations.size() == 0) begin
        $error("result transfer with no access outstanding");
        error_count++;
      end else begin
        want = pending_translations.pop_front();
        if (out_if.target !== want.target) begin
          $error("target: expected %0d, got %0d", want.target, out_if.target);
          error_count++;
        end
        if (out_if.phys_address !== want.phys_address) begin
          $error("phys_address: expected 0x%05h, got 0x%05h",
                 want.phys_address, out_if.phys_address);
          error_count++;
        end
        if (out_if.write_strobe !== want.write_strobe) begin
          $error("write_strobe: expected %0d, got %0d", want.write_strobe,
                 out_if.write_strobe);
          error_count++;
        end
        if (out_if.write_byte !== want.write_byte) begin
          $error("write_byte: expected 0x%02h, got 0x%02h", want.write_byte,
                 out_if.write_byte);
          error_count++;
        end
        if (out_if.paging_value !== want.paging_value) begin
          $error("paging_value: expected 0x%02h, got 0x%02h", want.paging_value,
                 out_if.paging_value);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // all four windows at their edges, rom write dropped, ram over rom
  task automatic test_windows();
    send_access(CMD_MEM_RD, 16'h0000, 8'h00, 1'b0, 1'b0);
    send_access(CMD_MEM_RD, 16'h3FFF, 8'h00, 1'b0, 1'b0);
    send_access(CMD_MEM_WR, 16'h1234, 8'hA5, 1'b0, 1'b0);
    send_access(CMD_MEM_WR, 16'h0000, 8'hFF, 1'b1, 1'b1);
    send_access(CMD_MEM_RD, 16'h4000, 8'h00, 1'b0, 1'b0);
    send_access(CMD_MEM_WR, 16'h7FFF, 8'h00, 1'b0, 1'b0);
    send_access(CMD_MEM_RD, 16'hBFFF, 8'h00, 1'b0, 1'b0);
    send_access(CMD_MEM_WR, 16'hC000, 8'h5A, 1'b0, 1'b0);
    send_access(CMD_MEM_RD, 16'hFFFF, 8'h00, 1'b0, 1'b0);
  endtask

  // port decode, lock bit, rom half select and the reset command in base mode
  task automatic test_paging_port();
    send_access(CMD_PORT_OUT, 16'hFFFD, 8'h07, 1'b0, 1'b0);  // not decoded
    send_access(CMD_PORT_OUT, 16'h0001, 8'h17, 1'b0, 1'b0);
    send_access(CMD_MEM_RD,   16'h0000, 8'h00, 1'b0, 1'b0);  // upper rom half
    send_access(CMD_MEM_RD,   16'hC000, 8'h00, 1'b0, 1'b0);
    send_access(CMD_PORT_OUT, PORT_FULL, 8'hFF, 1'b0, 1'b0); // top bits cut, locks
    send_access(CMD_PORT_OUT, PORT_FULL, 8'h00, 1'b0, 1'b0); // ignored while locked
    send_access(CMD_RESET,    16'hFFFF, 8'hFF, 1'b1, 1'b1);
  endtask

  // full latch store, high lock and the lock override of the wide modes
  task automatic test_extended_modes();
    set_mode(CFG_ENABLE_512K, 1'b1);
    send_access(CMD_PORT_OUT, PORT_FULL, 8'hC7, 1'b0, 1'b0); // all eight bits kept
    send_access(CMD_MEM_RD,   16'hFFFF, 8'h00, 1'b0, 1'b0);
    send_access(CMD_PORT_OUT, PORT_FULL, 8'hDB, 1'b0, 1'b1); // high lock: low six bits
    send_access(CMD_PORT_OUT, 16'h3FFD, 8'hC0, 1'b0, 1'b0);  // decoded, not exact port
    set_mode(CFG_ENABLE_1024K, 1'b1);
    send_access(CMD_PORT_OUT, PORT_FULL, 8'hFF, 1'b0, 1'b0);
    send_access(CMD_MEM_RD,   16'hFFFF, 8'h00, 1'b0, 1'b0);  // top of ram
    send_access(CMD_PORT_OUT, PORT_FULL, 8'h00, 1'b0, 1'b1); // locked and high lock
    send_access(CMD_PORT_OUT, PORT_FULL, 8'hE5, 1'b0, 1'b0); // lock overridden
    send_access(CMD_RESET,    16'h0000, 8'h00, 1'b0, 1'b0);
    set_mode(CFG_ENABLE_512K, 1'b0);
    // 1024k bit alone has no effect
    send_access(CMD_PORT_OUT, PORT_FULL, 8'hFF, 1'b0, 1'b0);
    send_access(CMD_MEM_RD,   16'hC000, 8'h00, 1'b0, 1'b0);
    send_access(CMD_RESET,    16'h0000, 8'h00, 1'b0, 1'b0);
  endtask

  // random traffic in each of the four mode settings
  task automatic test_random_modes();
    bit wide_512k[4]  = '{1'b0, 1'b1, 1'b1, 1'b0};
    bit wide_1024k[4] = '{1'b0, 1'b0, 1'b1, 1'b1};
    for (int m = 0; m < 4; m++) begin
      set_mode(CFG_ENABLE_512K, wide_512k[m]);
      set_mode(CFG_ENABLE_1024K, wide_1024k[m]);
      repeat (ItemsPerMode) send_random();
    end
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    gaps_on      = 1'b0;
    hold_off_req = 1'b1;
    repeat (40) send_random();
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_index_i        = CFG_ENABLE_512K;
    cfg_data_i         = '0;
    in_if.valid        = 1'b0;
    in_if.cmd          = CMD_MEM_RD;
    in_if.address      = '0;
    in_if.data_in      = '0;
    in_if.ram_over_rom = 1'b0;
    in_if.high_lock    = 1'b0;
    latch_model        = '0;
    mode_512k          = 1'b0;
    mode_1024k         = 1'b0;
    error_count        = 0;
    results_seen       = 0;
    burst_left         = 8;
    gaps_on            = 1'b1;
    hold_off_req       = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_windows();
    test_paging_port();
    test_extended_modes();
    test_random_modes();
    test_backpressure();
    wait_idle();

    $display("covered %0d reads, %0d writes, %0d port outputs, %0d latch resets",
             cmd_count[CMD_MEM_RD], cmd_count[CMD_MEM_WR], cmd_count[CMD_PORT_OUT],
             cmd_count[CMD_RESET]);
    $display("%0d results checked over all four mode settings, with stalls and a hold-off",
             results_seen);
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending_translations.size());
    $display("testbench NOT OK");
    $finish;
  end

endmodule
